### src/usb_cable_state_qualifier_assert.svh
// Assertion macros for the cable state qualifier.
// Used by the top-level RTL file in src; no other dependencies.
`ifndef USB_CABLE_STATE_QUALIFIER_ASSERT_SVH
`define USB_CABLE_STATE_QUALIFIER_ASSERT_SVH

`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define UCSQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ucsq assertion failed");
// antecedent implies consequent in the next cycle
`define UCSQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ucsq assertion failed");
`else
`define UCSQ_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define UCSQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### src/ucsq_pkg.sv
// Shared types and constants for the cable state qualifier.
// No dependencies; used by the result queue and the top level.
package ucsq_pkg;

   // cable states
   localparam logic [1:0] ST_UNKNOWN = 2'd0;
   localparam logic [1:0] ST_DISC    = 2'd1;
   localparam logic [1:0] ST_CHARGER = 2'd2;
   localparam logic [1:0] ST_PC      = 2'd3;

   // event codes
   localparam logic [2:0] EV_CHG_OFF = 3'd0;
   localparam logic [2:0] EV_USB_OFF = 3'd1;
   localparam logic [2:0] EV_CHG_ON  = 3'd2;
   localparam logic [2:0] EV_USB_ON  = 3'd3;
   localparam logic [2:0] EV_NOTICE  = 3'd4;

   // request types
   localparam logic REQ_REPORT = 1'b0;
   localparam logic REQ_TICK   = 1'b1;

   // supply kinds
   localparam logic [3:0] KIND_NONE    = 4'd0;
   localparam logic [3:0] KIND_USB     = 4'd1;
   localparam logic [3:0] KIND_CDP     = 4'd2;
   localparam logic [3:0] KIND_DCP     = 4'd3;
   localparam logic [3:0] KIND_HVDCP   = 4'd4;
   localparam logic [3:0] KIND_HVDCP_3 = 4'd5;
   localparam logic [3:0] KIND_FLOAT   = 4'd6;

   // configuration register indexes
   localparam logic CSR_BASE_DELAY = 1'b0;
   localparam logic CSR_CONN_DELAY = 1'b1;

   localparam logic [15:0] BASE_DELAY_RESET = 16'd100;
   localparam logic [15:0] CONN_DELAY_RESET = 16'd0;

   // result queue
   localparam int RSP_Q_DEPTH   = 4;
   localparam int RSP_Q_PTR_W   = $clog2(RSP_Q_DEPTH);
   localparam int RSP_Q_CNT_W   = $clog2(RSP_Q_DEPTH + 1);
   localparam int MAX_RESULTS   = 3;

   typedef struct packed {
      logic [2:0] event_code;
      logic [1:0] link_state;
      logic       last;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]                       count;
      rsp_item_type [MAX_RESULTS-1:0]   items;
   } rsp_group_type;

   function automatic logic [1:0] classify(input logic present, input logic [3:0] kind);
      logic [1:0] st;
      st = ST_DISC;
      if (present) begin
         case (kind) inside
            KIND_NONE, KIND_USB, KIND_CDP: st = ST_PC;
            KIND_DCP, KIND_HVDCP, KIND_HVDCP_3, KIND_FLOAT: st = ST_CHARGER;
            default: st = ST_DISC;
         endcase
      end
      return st;
   endfunction

endpackage

### src/ucsq_channels.sv
// Handshake channel interfaces for the cable state qualifier.
// No dependencies.
interface ucsq_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic       supply_present;
   logic [3:0] supply_kind;
   modport source (output valid, req_type, supply_present, supply_kind, input ready);
   modport sink   (input valid, req_type, supply_present, supply_kind, output ready);
endinterface

interface ucsq_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_code;
   logic [1:0] link_state;
   logic       last;
   modport source (output valid, event_code, link_state, last, input ready);
   modport sink   (input valid, event_code, link_state, last, output ready);
endinterface

interface ucsq_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### src/ucsq_rsp_queue.sv
// Result queue: takes a group of up to three results at once, drains one per cycle while rsp is ready.
// Depends on ucsq_pkg and ucsq_channels.
module ucsq_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ucsq_pkg::rsp_group_type group,
   output logic                   room,
   ucsq_rsp_if.source             rsp
);
   import ucsq_pkg::*;

   rsp_item_type            entry_ff [RSP_Q_DEPTH];
   logic [RSP_Q_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [RSP_Q_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [RSP_Q_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [RSP_Q_CNT_W-1:0]  cnt_after_pop;
   logic                    pop;

   assign pop           = rsp.valid && rsp.ready;
   assign cnt_after_pop = cnt_ff - RSP_Q_CNT_W'(pop);
   // a whole group must fit
   assign room = cnt_after_pop <= RSP_Q_CNT_W'(RSP_Q_DEPTH - MAX_RESULTS);

   assign rsp.valid       = cnt_ff != '0;
   assign rsp.event_code  = entry_ff[rd_ptr_ff].event_code;
   assign rsp.link_state  = entry_ff[rd_ptr_ff].link_state;
   assign rsp.last        = entry_ff[rd_ptr_ff].last;

   always_comb begin
      rd_ptr_in = rd_ptr_ff + RSP_Q_PTR_W'(pop);
      wr_ptr_in = wr_ptr_ff;
      cnt_in    = cnt_after_pop;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + RSP_Q_PTR_W'(group.count);
         cnt_in    = cnt_after_pop + RSP_Q_CNT_W'(group.count);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         if (push && (k < int'(group.count))) begin
            entry_ff[wr_ptr_ff + RSP_Q_PTR_W'(k)] <= group.items[k];
         end
      end
   end

endmodule

### src/usb_cable_state_qualifier.sv
// Cable state qualifier: debounces power-supply reports into a cable state
// and emits off/on events plus a state notice on every applied change.
//
// Channels: req_ch carries supply reports (req_type 0) and 1 ms ticks
// (req_type 1); rsp_ch carries events, each with the active cable state and
// a last flag on the final result (the notice) of one request. csr_ch writes
// base_delay (index 0) and connection_delay (index 1); it is always ready.
//
// A request transaction is registered in the input stage, then processed,
// once the result queue has room, against the timer and state registers.
// Results of that request are written into a four-entry result queue, whose
// head entry is presented on rsp_ch from the queue's registers.
// Requests are taken one per cycle as long as the queue has room for three
// results after this cycle's output; since the output moves one result a
// cycle while rsp_ch is ready, a request that applies a change with both an
// off and an on event holds the following request until the queue has room.
//
// Reset: registers load base_delay 100, connection_delay 0, both states
// unknown, timer stopped, queue empty. A stalled rsp_ch fills the queue and
// then drops req_ch.ready; nothing is lost.
`include "usb_cable_state_qualifier_assert.svh"

module usb_cable_state_qualifier (
   input  logic       clock,
   input  logic       reset,
   ucsq_req_if.sink   req_ch,
   ucsq_rsp_if.source rsp_ch,
   ucsq_csr_if.sink   csr_ch
);
   import ucsq_pkg::*;

   // configuration
   logic [15:0] base_delay_ff;
   logic [15:0] conn_delay_ff;

   // input stage
   logic       in_valid_ff, in_valid_in;
   logic       in_type_ff;
   logic       in_present_ff;
   logic [3:0] in_kind_ff;

   // qualifier state
   logic [1:0]  reported_ff, reported_in;
   logic [1:0]  active_ff, active_in;
   logic        running_ff, running_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [15:0] length_ff, length_in;

   logic          proc_fire;
   logic          q_room;
   rsp_group_type group;

   assign proc_fire    = in_valid_ff && q_room;
   assign req_ch.ready = !in_valid_ff || proc_fire;
   assign csr_ch.ready = 1'b1;
   assign in_valid_in  = (req_ch.valid && req_ch.ready) || (in_valid_ff && !proc_fire);

   always_comb begin
      logic [1:0]  cur;
      logic [1:0]  target;
      logic        do_apply;
      logic [15:0] delay;
      logic [1:0]  n;

      reported_in  = reported_ff;
      active_in    = active_ff;
      running_in   = running_ff;
      remaining_in = remaining_ff;
      length_in    = length_ff;
      group        = '0;
      do_apply     = 1'b0;
      target       = reported_ff;
      delay        = base_delay_ff;
      n            = '0;
      cur          = classify(in_present_ff, in_kind_ff);

      if (in_type_ff == REQ_TICK) begin
         if (running_ff) begin
            if (remaining_ff > 16'd1) begin
               remaining_in = remaining_ff - 16'd1;
            end else begin
               do_apply = 1'b1;
               target   = reported_ff;
            end
         end
      end else begin
         reported_in = cur;
         if (reported_ff != cur) begin
            if (cur == ST_DISC) begin
               do_apply = 1'b1;
               target   = ST_DISC;
            end else begin
               if (cur == ST_PC && reported_ff != ST_UNKNOWN && conn_delay_ff > base_delay_ff) begin
                  delay = conn_delay_ff;
               end
               // same-length running timer keeps its count
               if (!(running_ff && length_ff == delay)) begin
                  running_in   = 1'b1;
                  remaining_in = delay;
                  length_in    = delay;
               end
            end
         end
      end

      if (do_apply) begin
         running_in   = 1'b0;
         remaining_in = '0;
         length_in    = '0;
         if (active_ff != target) begin
            active_in = target;
            if (active_ff == ST_CHARGER) begin
               group.items[n] = '{event_code: EV_CHG_OFF, link_state: target, last: 1'b0};
               n = n + 2'd1;
            end else if (active_ff == ST_PC) begin
               group.items[n] = '{event_code: EV_USB_OFF, link_state: target, last: 1'b0};
               n = n + 2'd1;
            end
            if (target == ST_CHARGER) begin
               group.items[n] = '{event_code: EV_CHG_ON, link_state: target, last: 1'b0};
               n = n + 2'd1;
            end else if (target == ST_PC) begin
               group.items[n] = '{event_code: EV_USB_ON, link_state: target, last: 1'b0};
               n = n + 2'd1;
            end
            group.items[n] = '{event_code: EV_NOTICE, link_state: target, last: 1'b1};
            n = n + 2'd1;
         end
      end
      group.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_delay_ff <= BASE_DELAY_RESET;
         conn_delay_ff <= CONN_DELAY_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            CSR_BASE_DELAY: base_delay_ff <= csr_ch.data;
            CSR_CONN_DELAY: conn_delay_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_type_ff    <= req_ch.req_type;
         in_present_ff <= req_ch.supply_present;
         in_kind_ff    <= req_ch.supply_kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reported_ff  <= ST_UNKNOWN;
         active_ff    <= ST_UNKNOWN;
         running_ff   <= 1'b0;
         remaining_ff <= '0;
         length_ff    <= '0;
      end else if (proc_fire) begin
         reported_ff  <= reported_in;
         active_ff    <= active_in;
         running_ff   <= running_in;
         remaining_ff <= remaining_in;
         length_ff    <= length_in;
      end
   end

   ucsq_rsp_queue u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (proc_fire),
      .group (group),
      .room  (q_room),
      .rsp   (rsp_ch)
   );

   // a timer only runs while a charger or PC report waits to settle
   `UCSQ_ASSERT_IMPLY(a_run_state, clock, reset, running_ff,
      reported_ff == ST_CHARGER || reported_ff == ST_PC)
   // count never exceeds the loaded length
   `UCSQ_ASSERT_IMPLY(a_run_count, clock, reset, running_ff, remaining_ff <= length_ff)
   // a stopped timer is fully cleared
   `UCSQ_ASSERT_IMPLY(a_stop_clear, clock, reset, !running_ff,
      remaining_ff == '0 && length_ff == '0)
   // a processed request that yields results changes the active state
   `UCSQ_ASSERT_NEXT(a_group_change, clock, reset, proc_fire && group.count != '0,
      active_ff != $past(active_ff))

endmodule
